// ----- rtl/pfde_pkg.sv -----
// Playfair digraph encipherer: shared types and constants.
// Used by pfde_encipher and playfair_digraph_encrypt; no dependencies.
package pfde_pkg;

  localparam int unsigned SqDim    = 5;
  localparam int unsigned CodeW    = 5;
  localparam int unsigned RowW     = SqDim * CodeW;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic [CodeW-1:0] letter_t;
  typedef logic [RowW-1:0]  row_t;

  localparam letter_t FillerCode = 5'd23;  // X

  // Reset square YQDLG / MJXFU / VWCPB / OSKRE / THNAI
  localparam row_t RowReset [SqDim] = '{
    25'd6655512, 25'd21159212, 25'd1542869, 25'd4762190, 25'd8402163
  };

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW0 = 3'd0,
    CFG_ROW1 = 3'd1,
    CFG_ROW2 = 3'd2,
    CFG_ROW3 = 3'd3,
    CFG_ROW4 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    last;
  } pair_t;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    absent;
  } enc_t;

endpackage

// ----- rtl/playfair_digraph_encrypt.sv -----
// Playfair digraph encipherer, top level: pairing front end, pair queue,
// output register and key square registers. Depends on pfde_pkg, pfde_encipher.
// A cipher pair passes through the pair queue and then the output register.
// Throughput: one letter per cycle while the output is not stalled; a doubled final
// letter makes two pairs and holds the input off while the second pair drains.
// Reset: asynchronous, active low; clears the pending letter, the pair slots
// and the output valid, and loads the default key square.
module playfair_digraph_encrypt import pfde_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [4:0] plain_letter
  input  logic               s_axis_tlast,   // final_letter
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // [4:0] cipher_first, [9:5] cipher_second
  output logic               m_axis_tuser,   // absent_flag
  output logic               m_axis_tlast,   // final_pair
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RowW-1:0]    cfg_data_i
);

  row_t [SqDim-1:0] square_q;
  letter_t          held_letter_q, held_letter_d;
  logic             held_valid_q, held_valid_d;
  pair_t            p0_q, p0_d, p1_q, p1_d;
  logic             p0_valid_q, p0_valid_d, p1_valid_q, p1_valid_d;
  logic             out_valid_q;
  enc_t             out_q;
  logic             out_last_q;
  enc_t             enc;
  logic             adv, in_acc;
  letter_t          letter;
  logic             last;

  assign letter = s_axis_tdata[CodeW-1:0];
  assign last   = s_axis_tlast;

  // advance the head pair into the output register
  assign adv           = p0_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~p1_valid_q & (~p0_valid_q | adv);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    held_letter_d = held_letter_q;
    held_valid_d  = held_valid_q;
    p0_valid_d    = p0_valid_q;
    p0_d          = p0_q;
    p1_valid_d    = p1_valid_q;
    p1_d          = p1_q;

    if (adv) begin
      p0_valid_d = p1_valid_q;
      p0_d       = p1_q;
      p1_valid_d = 1'b0;
    end

    if (in_acc) begin
      if (!held_valid_q) begin
        if (last) begin
          p0_valid_d = 1'b1;
          p0_d       = '{a: letter, b: FillerCode, last: 1'b1};
        end else begin
          held_letter_d = letter;
          held_valid_d  = 1'b1;
        end
      end else if (held_letter_q != letter) begin
        p0_valid_d    = 1'b1;
        p0_d          = '{a: held_letter_q, b: letter, last: last};
        held_letter_d = '0;
        held_valid_d  = 1'b0;
      end else begin
        // doubled letter: pad with X and keep the new letter pending; a final one is queued padded with X
        p0_valid_d = 1'b1;
        p0_d       = '{a: held_letter_q, b: FillerCode, last: 1'b0};
        if (last) begin
          p1_valid_d    = 1'b1;
          p1_d          = '{a: letter, b: FillerCode, last: 1'b1};
          held_letter_d = '0;
          held_valid_d  = 1'b0;
        end
      end
    end
  end

  pfde_encipher u_encipher (
    .square_i (square_q),
    .pair_i   (p0_q),
    .enc_o    (enc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_letter_q <= '0;
      held_valid_q  <= 1'b0;
      p0_valid_q    <= 1'b0;
      p1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      for (int r = 0; r < SqDim; r++) begin
        square_q[r] <= RowReset[r];
      end
    end else begin
      held_letter_q <= held_letter_d;
      held_valid_q  <= held_valid_d;
      p0_valid_q    <= p0_valid_d;
      p1_valid_q    <= p1_valid_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_idx_i <= CFG_ROW4)) begin
        square_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    p1_q <= p1_d;
    if (adv) begin
      out_q      <= enc;
      out_last_q <= p0_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.second, out_q.first};
  assign m_axis_tuser  = out_q.absent;
  assign m_axis_tlast  = out_last_q;

  a_p1_needs_p0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q |-> p0_valid_q)
    else $error("second pair slot filled without a head pair");

  a_idle_held_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_valid_q |-> (held_letter_q == '0))
    else $error("stale pending letter");

  a_double_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && held_valid_q && (held_letter_q == letter) && last)
      |=> (p1_valid_q && p0_valid_q && !held_valid_q))
    else $error("doubled final letter did not queue two pairs");

  a_out_from_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(p0_valid_q))
    else $error("output loaded without a queued pair");

endmodule

// ----- rtl/pfde_encipher.sv -----
// Combinational Playfair encipher of one letter pair against the key square.
// Depends on pfde_pkg.
module pfde_encipher import pfde_pkg::*; (
  input  row_t  [SqDim-1:0] square_i,
  input  pair_t             pair_i,
  output enc_t              enc_o
);

  letter_t              sq_cell [SqDim][SqDim];
  logic [SqDim-1:0]     hit_a  [SqDim];
  logic [SqDim-1:0]     hit_b  [SqDim];
  logic [SqDim-1:0]     oh_a   [SqDim];
  logic [SqDim-1:0]     oh_b   [SqDim];
  logic [SqDim-1:0]     row_a, col_a, row_b, col_b;
  logic                 seen_a, seen_b;
  logic                 same_row, same_col;
  letter_t              row_x, row_y, col_x, col_y, rect_x, rect_y;

  always_comb begin
    for (int r = 0; r < SqDim; r++) begin
      for (int c = 0; c < SqDim; c++) begin
        sq_cell[r][c] = square_i[r][c*CodeW +: CodeW];
        hit_a[r][c]   = (sq_cell[r][c] == pair_i.a);
        hit_b[r][c]   = (sq_cell[r][c] == pair_i.b);
      end
    end

    // keep only the first hit, rows first, then columns
    seen_a = 1'b0;
    seen_b = 1'b0;
    for (int r = 0; r < SqDim; r++) begin
      for (int c = 0; c < SqDim; c++) begin
        oh_a[r][c] = hit_a[r][c] & ~seen_a;
        oh_b[r][c] = hit_b[r][c] & ~seen_b;
        seen_a     = seen_a | hit_a[r][c];
        seen_b     = seen_b | hit_b[r][c];
      end
    end

    row_a = '0;
    col_a = '0;
    row_b = '0;
    col_b = '0;
    for (int r = 0; r < SqDim; r++) begin
      for (int c = 0; c < SqDim; c++) begin
        row_a[r] = row_a[r] | oh_a[r][c];
        col_a[c] = col_a[c] | oh_a[r][c];
        row_b[r] = row_b[r] | oh_b[r][c];
        col_b[c] = col_b[c] | oh_b[r][c];
      end
    end

    // second letter anywhere in the first letter's row or column
    same_row = 1'b0;
    same_col = 1'b0;
    for (int r = 0; r < SqDim; r++) begin
      for (int c = 0; c < SqDim; c++) begin
        same_row = same_row | (row_a[r] & hit_b[r][c]);
        same_col = same_col | (col_a[c] & hit_b[r][c]);
      end
    end

    row_x  = '0;
    row_y  = '0;
    col_x  = '0;
    col_y  = '0;
    rect_x = '0;
    rect_y = '0;
    for (int r = 0; r < SqDim; r++) begin
      for (int c = 0; c < SqDim; c++) begin
        row_x  = row_x  | ({CodeW{oh_a[r][c]}} & sq_cell[r][(c+1) % SqDim]);
        row_y  = row_y  | ({CodeW{oh_b[r][c]}} & sq_cell[r][(c+1) % SqDim]);
        col_x  = col_x  | ({CodeW{oh_a[r][c]}} & sq_cell[(r+1) % SqDim][c]);
        col_y  = col_y  | ({CodeW{oh_b[r][c]}} & sq_cell[(r+1) % SqDim][c]);
        rect_x = rect_x | ({CodeW{row_a[r] & col_b[c]}} & sq_cell[r][c]);
        rect_y = rect_y | ({CodeW{row_b[r] & col_a[c]}} & sq_cell[r][c]);
      end
    end

    enc_o.absent = ~(seen_a & seen_b);
    if (enc_o.absent) begin
      enc_o.first  = '0;
      enc_o.second = '0;
    end else if (same_row) begin
      enc_o.first  = row_x;
      enc_o.second = row_y;
    end else if (same_col) begin
      enc_o.first  = col_x;
      enc_o.second = col_y;
    end else begin
      enc_o.first  = rect_x;
      enc_o.second = rect_y;
    end
  end

endmodule

// ----- dv/playfair_digraph_encrypt_tb.sv -----
`timescale 1ns / 1ps
// Testbench for playfair_digraph_encrypt: streams letter messages with bursty input
// and output stalls, predicts every cipher pair and checks them in order.
// Depends on pfde_pkg and the playfair_digraph_encrypt RTL.
module playfair_digraph_encrypt_tb;
  import pfde_pkg::*;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned RandomLetters = 550;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned AlphabetSize  = SqDim * SqDim + 1;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    absent;
    logic    last;
  } cipher_pair_t;

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;  // [4:0] plain_letter
  logic               s_axis_tlast  = 1'b0;  // final_letter
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;  // [4:0] cipher_first, [9:5] cipher_second
  logic               m_axis_tuser;  // absent_flag
  logic               m_axis_tlast;  // final_pair
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [RowW-1:0]    cfg_data_i    = '0;

  // Mirror of the key square and the pairing front end
  row_t         key_rows [SqDim];
  row_t         next_rows [SqDim];
  letter_t      held_letter;
  logic         held_valid;
  cipher_pair_t cipher_pairs_q [$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned rx_phase    = 0;
  rx_mode_e    stall_mode  = RX_OPEN;

  playfair_digraph_encrypt dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic letter_t ltr(byte ch);
    return letter_t'(ch - "A");
  endfunction

  function automatic letter_t cell_at(int unsigned r, int unsigned c);
    return key_rows[r % SqDim][CodeW * (c % SqDim) +: CodeW];
  endfunction

  // First match, scanning rows then columns
  function automatic bit find_cell(letter_t code, output int unsigned r,
                                   output int unsigned c);
    r = 0;
    c = 0;
    for (int i = 0; i < SqDim; i++)
      for (int j = 0; j < SqDim; j++)
        if (cell_at(i, j) == code) begin
          r = i;
          c = j;
          return 1'b1;
        end
    return 1'b0;
  endfunction

  function automatic bit row_has(int unsigned r, letter_t code);
    for (int j = 0; j < SqDim; j++)
      if (cell_at(r, j) == code) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit col_has(int unsigned c, letter_t code);
    for (int i = 0; i < SqDim; i++)
      if (cell_at(i, c) == code) return 1'b1;
    return 1'b0;
  endfunction

  function automatic cipher_pair_t cipher_pair(letter_t a, letter_t b, logic last);
    int unsigned  ra, ca, rb, cb;
    bit           found_a, found_b;
    cipher_pair_t res;
    found_a = find_cell(a, ra, ca);
    found_b = find_cell(b, rb, cb);
    res = '0;
    res.last = last;
    if (!found_a || !found_b) begin
      res.absent = 1'b1;
    end else if (row_has(ra, b)) begin
      res.first  = cell_at(ra, ca + 1);
      res.second = cell_at(rb, cb + 1);
    end else if (col_has(ca, b)) begin
      res.first  = cell_at(ra + 1, ca);
      res.second = cell_at(rb + 1, cb);
    end else begin
      res.first  = cell_at(ra, cb);
      res.second = cell_at(rb, ca);
    end
    return res;
  endfunction

  // Advance the pairing state by one accepted letter and queue its cipher pairs
  function automatic void absorb_letter(letter_t letter, logic last);
    if (!held_valid) begin
      if (last) begin
        cipher_pairs_q.push_back(cipher_pair(letter, FillerCode, 1'b1));
      end else begin
        held_letter = letter;
        held_valid  = 1'b1;
      end
    end else if (held_letter != letter) begin
      cipher_pairs_q.push_back(cipher_pair(held_letter, letter, last));
      held_valid = 1'b0;
    end else begin
      // doubled letter: pad with X, the new copy stays pending unless final, then it is padded with X
      cipher_pairs_q.push_back(cipher_pair(held_letter, FillerCode, 1'b0));
      if (last) begin
        cipher_pairs_q.push_back(cipher_pair(letter, FillerCode, 1'b1));
        held_valid = 1'b0;
      end
    end
  endfunction

  function automatic void check_field(string name, letter_t want, letter_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_letter(letter_t letter, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(8 - CodeW){1'b0}}, letter};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_letter(letter, last);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (cipher_pairs_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Load next_rows into the square; optionally follow with a write to an unused index
  task automatic program_square(bit stray);
    for (int i = 0; i < SqDim; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= next_rows[i];
      @(posedge clk_i);
      key_rows[i] = next_rows[i];
    end
    if (stray) begin
      cfg_idx_i  <= CfgIdxW'($urandom_range(SqDim, (1 << CfgIdxW) - 1));
      cfg_data_i <= RowW'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Reset square YQDLG / MJXFU / VWCPB / OSKRE / THNAI
  task automatic test_pairing_rules();
    send_letter(ltr("Y"), 1'b0);  // same row, wraps to column 0
    send_letter(ltr("G"), 1'b0);
    send_letter(ltr("Y"), 1'b0);  // same column
    send_letter(ltr("T"), 1'b0);
    send_letter(ltr("D"), 1'b0);  // rectangle
    send_letter(ltr("S"), 1'b0);
    send_letter(ltr("L"), 1'b0);  // doubled letter mid-message
    send_letter(ltr("L"), 1'b0);
    send_letter(ltr("B"), 1'b0);
    send_letter(ltr("E"), 1'b0);  // doubled final letter gives two pairs
    send_letter(ltr("E"), 1'b1);
    send_letter(ltr("K"), 1'b1);  // odd final letter
    send_letter(ltr("X"), 1'b0);  // X padded with X
    send_letter(ltr("X"), 1'b1);
    send_letter(ltr("A"), 1'b0);  // Z is not in the square
    send_letter(ltr("Z"), 1'b1);
    send_letter('1, 1'b0);        // codes past Z
    send_letter(ltr("Z") + 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_square_extremes();
    // every cell A: only A is found
    foreach (next_rows[i]) next_rows[i] = '0;
    program_square(1'b0);
    send_letter(ltr("A"), 1'b0);
    send_letter(ltr("B"), 1'b1);
    send_letter(ltr("A"), 1'b1);
    wait_idle();

    // every cell code 31
    foreach (next_rows[i]) next_rows[i] = '1;
    program_square(1'b1);
    send_letter('1, 1'b0);
    send_letter('1, 1'b1);
    wait_idle();

    // identical rows: repeats resolve to the first match
    foreach (next_rows[i]) next_rows[i] = {ltr("D"), ltr("C"), ltr("B"), ltr("A"), ltr("X")};
    program_square(1'b0);
    send_letter(ltr("X"), 1'b0);
    send_letter(ltr("X"), 1'b1);
    send_letter(ltr("A"), 1'b0);
    send_letter(ltr("C"), 1'b0);
    send_letter(ltr("D"), 1'b1);
    wait_idle();

    foreach (next_rows[i]) next_rows[i] = RowReset[i];
    program_square(1'b1);
    send_letter(ltr("Q"), 1'b0);
    send_letter(ltr("W"), 1'b1);
    wait_idle();
  endtask

  task automatic test_random_messages();
    letter_t     pool [AlphabetSize];
    letter_t     tmp, letter, prev;
    int unsigned sent, phase_letters, phase_target, msg_len, roll, j, r, c;
    sent = 0;
    while (sent < RandomLetters) begin
      // shuffled alphabet, one letter left out
      for (int i = 0; i < AlphabetSize; i++) pool[i] = letter_t'(i);
      for (int i = AlphabetSize - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = pool[i];
        pool[i] = pool[j];
        pool[j] = tmp;
      end
      for (int i = 0; i < SqDim * SqDim; i++)
        next_rows[i / SqDim][CodeW * (i % SqDim) +: CodeW] = pool[i];
      roll = $urandom_range(0, 5);
      if (roll == 0) begin
        // raw bits: repeated cells and codes past Z
        foreach (next_rows[i]) next_rows[i] = RowW'($urandom);
      end else if (roll == 1) begin
        repeat ($urandom_range(1, 5)) begin
          r = $urandom_range(0, SqDim - 1);
          c = $urandom_range(0, SqDim - 1);
          next_rows[r][CodeW * c +: CodeW] = letter_t'($urandom_range(0, (1 << CodeW) - 1));
        end
      end
      program_square($urandom_range(0, 3) == 0);

      phase_letters = 0;
      phase_target  = $urandom_range(30, 90);
      prev = FillerCode;
      while (phase_letters < phase_target) begin
        msg_len = $urandom_range(1, 14);
        for (int k = 0; k < msg_len; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 18) letter = prev;
          else if (roll < 24) letter = FillerCode;
          else if (roll < 32) letter = letter_t'($urandom_range(0, (1 << CodeW) - 1));
          else letter = cell_at($urandom_range(0, SqDim - 1), $urandom_range(0, SqDim - 1));
          send_letter(letter, k == msg_len - 1);
          prev = letter;
        end
        phase_letters += msg_len;
      end
      sent += phase_letters;
      wait_idle();
    end
  endtask

  // Output stall pattern: switch between open, coin-flip, sparse and periodic
  always @(posedge clk_i) begin
    rx_phase++;
    if (stall_left == 0) begin
      stall_mode = rx_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= rx_phase[2];
    endcase
  end

  always @(posedge clk_i) begin : check_pairs
    cipher_pair_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_pairs_q.size() == 0) begin
        $error("cipher pair %h arrived with none expected", m_axis_tdata[9:0]);
        fail_count++;
      end else begin
        want = cipher_pairs_q.pop_front();
        check_field("cipher_first", want.first, m_axis_tdata[4:0]);
        check_field("cipher_second", want.second, m_axis_tdata[9:5]);
        check_field("absent_flag", want.absent, m_axis_tuser);
        check_field("final_pair", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    foreach (key_rows[i]) key_rows[i] = RowReset[i];
    held_letter = '0;
    held_valid  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pairing_rules();
    test_square_extremes();
    test_random_messages();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
